// ===== design/assert_macros.svh =====
// Assertion macros shared by the receiver report block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/rtcprr_pkg.sv =====
// Shared types and constants for the receiver report block.
// No dependencies; imported by every module of the block.
package rtcprr_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int SLOT_W      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] MAX_BLOCKS_RESET = 5'd31;

  localparam logic signed [31:0] CUM_MAX = 32'sh007f_ffff;
  localparam logic signed [31:0] CUM_MIN = -(32'sd1 <<< 23);

  // delay fraction: floor(usec * 2^16 / 10^6) via reciprocal plus one correction
  localparam logic [20:0] USEC_RECIP    = 21'd1099511;
  localparam int          USEC_SHIFT    = 24;
  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;

  localparam int FRAC_BITS = 8;
  localparam int FSTEP_W   = $clog2(FRAC_BITS);

  typedef struct packed {
    logic [31:0] ssrc;
    logic [31:0] exp_int;
    logic [31:0] rec_int;
    logic [31:0] expected;
    logic [31:0] recv;
    logic [31:0] ext_seq;
    logic [31:0] jitter;
    logic [31:0] sr_middle;
    logic        sr_seen;
    logic [15:0] esec;
    logic [19:0] eusec;
    logic [4:0]  block_number;
  } rr_job_t;

endpackage

// ===== design/rtcprr_front.sv =====
// Front end: takes items, looks up per-source prior counts, decides on a block.
// Depends on rtcprr_pkg; feeds jobs to rtcprr_queue.
module rtcprr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [3:0]       source_index,
  input  logic             start_packet,
  input  logic [31:0]      source_ssrc,
  input  logic [31:0]      seq_cycles,
  input  logic [15:0]      max_seq,
  input  logic [15:0]      first_seq,
  input  logic [31:0]      received_count,
  input  logic [31:0]      jitter_in,
  input  logic [63:0]      ntp_last_sr,
  input  logic             sr_seen,
  input  logic [15:0]      elapsed_seconds,
  input  logic [19:0]      elapsed_microseconds,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_data,
  output logic             job_push,
  output rtcprr_pkg::rr_job_t job,
  input  logic             job_full
);
  import rtcprr_pkg::*;

  logic        held;
  logic [3:0]  source_index_r;
  logic [31:0] ssrc_r;
  logic [31:0] recv_r;
  logic [31:0] jitter_r;
  logic [31:0] sr_middle_r;
  logic        sr_seen_r;
  logic [15:0] esec_r;
  logic [19:0] eusec_r;
  logic [31:0] expected_r;
  logic [31:0] ext_seq_r;
  logic [4:0]  block_count;
  logic [4:0]  max_blocks;
  logic [31:0] exp_hist [NUM_SOURCES];
  logic [31:0] rec_hist [NUM_SOURCES];

  logic              in_range;
  logic [SLOT_W-1:0] slot;
  logic              hit;
  logic              finish;

  assign full     = held;
  assign in_range = int'(source_index_r) < NUM_SOURCES;
  assign slot     = source_index_r[SLOT_W-1:0];
  assign hit      = in_range && (rec_hist[slot] != recv_r) && (block_count < max_blocks);
  assign job_push = held && hit && !job_full;
  assign finish   = held && (!hit || !job_full);

  always_comb begin
    job.ssrc         = ssrc_r;
    job.exp_int      = expected_r - exp_hist[slot];
    job.rec_int      = recv_r - rec_hist[slot];
    job.expected     = expected_r;
    job.recv         = recv_r;
    job.ext_seq      = ext_seq_r;
    job.jitter       = jitter_r;
    job.sr_middle    = sr_middle_r;
    job.sr_seen      = sr_seen_r;
    job.esec         = esec_r;
    job.eusec        = eusec_r;
    job.block_number = block_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      block_count <= '0;
      max_blocks  <= MAX_BLOCKS_RESET;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        exp_hist[i] <= '0;
        rec_hist[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_blocks <= cfg_data;
      end
      if (push && !held) begin
        held           <= 1'b1;
        source_index_r <= source_index;
        ssrc_r         <= source_ssrc;
        recv_r         <= received_count;
        jitter_r       <= jitter_in;
        sr_middle_r    <= {ntp_last_sr[47:32], ntp_last_sr[31:16]};
        sr_seen_r      <= sr_seen;
        esec_r         <= elapsed_seconds;
        eusec_r        <= elapsed_microseconds;
        expected_r     <= seq_cycles + 32'(max_seq) - 32'(first_seq) + 32'd1;
        ext_seq_r      <= seq_cycles + 32'(max_seq);
        if (start_packet) begin
          block_count <= '0;
        end
      end
      if (finish) begin
        held <= 1'b0;
      end
      if (job_push) begin
        exp_hist[slot] <= expected_r;
        rec_hist[slot] <= recv_r;
        block_count    <= block_count + 5'd1;
      end
    end
  end

endmodule

// ===== design/rtcprr_queue.sv =====
// Short job queue between front end and back end.
// Depends on rtcprr_pkg for the job type and depth.
module rtcprr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rtcprr_pkg::rr_job_t wr_data,
  output logic                full,
  input  logic                pop,
  output rtcprr_pkg::rr_job_t rd_data,
  output logic                empty
);
  import rtcprr_pkg::*;

  rr_job_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/rtcprr_back.sv =====
// Back end: loss arithmetic, serial fraction divider, delay scaling, result register.
// Depends on rtcprr_pkg; takes jobs from rtcprr_queue.
module rtcprr_back (
  input  logic                clk,
  input  logic                rst,
  output logic                job_pop,
  input  rtcprr_pkg::rr_job_t job_in,
  input  logic                job_empty,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         report_ssrc,
  output logic [7:0]          fraction_lost,
  output logic signed [23:0]  cumulative_lost,
  output logic [31:0]         extended_highest_seq,
  output logic [31:0]         jitter_out,
  output logic [31:0]         last_sr_middle,
  output logic [31:0]         delay_since_sr,
  output logic [4:0]          block_number
);
  import rtcprr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state;
  rr_job_t              job;
  logic                 out_valid;
  logic [31:0]          lost;
  logic [31:0]          cum_diff;
  logic signed [23:0]   cum;
  logic [40:0]          usec_prod;
  logic [16:0]          q_est;
  logic [36:0]          q_scaled;
  logic [31:0]          delay;
  logic [31:0]          rem;
  logic [FRAC_BITS-1:0] frac;
  logic [FSTEP_W-1:0]   step;

  logic [36:0] usec_rem;
  logic [16:0] q_fix;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic        out_load;

  assign empty    = !out_valid;
  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign usec_rem = {1'b0, job.eusec, 16'b0} - q_scaled;
  assign q_fix    = q_est + 17'(usec_rem >= 37'(USEC_PER_SEC));
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, job.exp_int};
  assign out_load = (state == S_DONE) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job   <= job_in;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          lost      <= job.exp_int - job.rec_int;
          cum_diff  <= job.expected - job.recv - 32'd1;
          usec_prod <= job.eusec * USEC_RECIP;
          state     <= S_MUL;
        end
        S_MUL: begin
          q_est    <= usec_prod[40:USEC_SHIFT];
          q_scaled <= usec_prod[40:USEC_SHIFT] * USEC_PER_SEC;
          if ($signed(cum_diff) > CUM_MAX) begin
            cum <= CUM_MAX[23:0];
          end else if ($signed(cum_diff) < CUM_MIN) begin
            cum <= CUM_MIN[23:0];
          end else begin
            cum <= cum_diff[23:0];
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          delay <= job.sr_seen ? ({job.esec, 16'b0} + 32'(q_fix)) : 32'd0;
          rem   <= lost;
          step  <= '0;
          if (job.exp_int == '0 || $signed(lost) <= 0) begin
            frac  <= '0;
            state <= S_DONE;
          end else if (lost >= job.exp_int) begin
            frac  <= '1;
            state <= S_DONE;
          end else begin
            frac  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          rem  <= rem_ge ? 32'(rem_sh - {1'b0, job.exp_int}) : rem_sh[31:0];
          frac <= {frac[FRAC_BITS-2:0], rem_ge};
          step <= step + FSTEP_W'(1);
          if (step == FSTEP_W'(FRAC_BITS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            report_ssrc          <= job.ssrc;
            fraction_lost        <= frac;
            cumulative_lost      <= cum;
            extended_highest_seq <= job.ext_seq;
            jitter_out           <= job.jitter;
            last_sr_middle       <= job.sr_middle;
            delay_since_sr       <= delay;
            block_number         <= job.block_number;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/rtcp_receiver_report_block.sv =====
// Top level of the RTCP receiver report block generator.
// Depends on rtcprr_pkg, rtcprr_front, rtcprr_queue, rtcprr_back, assert_macros.svh.

// Each item holds one source's reception statistics; when packets have arrived
// since that source's last report and the packet still has room, one report
// block comes out of the result register. The front end registers an item and
// decides on it in the next cycle, so full is high for one cycle after each
// transfer unless the job queue is full. The back end steps jobs through prep,
// multiply, check and done, adding eight restoring divider steps unless the
// loss fraction is zero or saturated, and takes a new job only after the result
// register takes the last. A two-entry job queue lets the front end keep taking
// items while the back end works or a result waits. Per-source prior counts are
// cleared at reset. The user must write max_blocks through cfg_we and cfg_data
// only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module rtcp_receiver_report_block (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         source_index,
  input  logic               start_packet,
  input  logic [31:0]        source_ssrc,
  input  logic [31:0]        seq_cycles,
  input  logic [15:0]        max_seq,
  input  logic [15:0]        first_seq,
  input  logic [31:0]        received_count,
  input  logic [31:0]        jitter_in,
  input  logic [63:0]        ntp_last_sr,
  input  logic               sr_seen,
  input  logic [15:0]        elapsed_seconds,
  input  logic [19:0]        elapsed_microseconds,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        report_ssrc,
  output logic [7:0]         fraction_lost,
  output logic signed [23:0] cumulative_lost,
  output logic [31:0]        extended_highest_seq,
  output logic [31:0]        jitter_out,
  output logic [31:0]        last_sr_middle,
  output logic [31:0]        delay_since_sr,
  output logic [4:0]         block_number
);
  import rtcprr_pkg::*;

  rr_job_t q_wr_data;
  rr_job_t q_rd_data;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;

  rtcprr_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .source_index         (source_index),
    .start_packet         (start_packet),
    .source_ssrc          (source_ssrc),
    .seq_cycles           (seq_cycles),
    .max_seq              (max_seq),
    .first_seq            (first_seq),
    .received_count       (received_count),
    .jitter_in            (jitter_in),
    .ntp_last_sr          (ntp_last_sr),
    .sr_seen              (sr_seen),
    .elapsed_seconds      (elapsed_seconds),
    .elapsed_microseconds (elapsed_microseconds),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .job_push             (q_push),
    .job                  (q_wr_data),
    .job_full             (q_full)
  );

  rtcprr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  rtcprr_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .job_pop              (q_pop),
    .job_in               (q_rd_data),
    .job_empty            (q_empty),
    .empty                (empty),
    .pop                  (pop),
    .report_ssrc          (report_ssrc),
    .fraction_lost        (fraction_lost),
    .cumulative_lost      (cumulative_lost),
    .extended_highest_seq (extended_highest_seq),
    .jitter_out           (jitter_out),
    .last_sr_middle       (last_sr_middle),
    .delay_since_sr       (delay_since_sr),
    .block_number         (block_number)
  );

  `ASSERT_NEVER(a_queue_overflow, q_push && q_full, "job pushed into full queue")
  `ASSERT_NEVER(a_queue_underflow, q_pop && q_empty, "job taken from empty queue")
  `ASSERT_CLK(a_push_lands, q_push |=> !q_empty, "pushed job missing from queue")

endmodule
